@@ rtl/core/rai_pkg.sv @@
// Shared types, constants and helper functions of the ray and rectangle intersection block.
// Used by rai_tdiv, rai_uvdiv and ray_axis_rect_intersect; depends on nothing.
package rai_pkg;

  localparam int DATA_W     = 32;
  localparam int FRAC_BITS  = 16;
  localparam int UV_BITS    = 16;
  localparam int TDIV_STEPS = DATA_W;
  localparam int UV_STEPS   = UV_BITS + 1;
  // Width of a hit point coordinate before saturation.
  localparam int PT_W       = 2 * DATA_W - FRAC_BITS + 1;

  localparam logic [1:0] AXIS_Z = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_X = 2'd2;

  typedef enum logic [2:0] {
    REG_PLANE_AXIS  = 3'd0,
    REG_PLANE_POS   = 3'd1,
    REG_FIRST_LOW   = 3'd2,
    REG_FIRST_HIGH  = 3'd3,
    REG_SECOND_LOW  = 3'd4,
    REG_SECOND_HIGH = 3'd5,
    REG_MATERIAL    = 3'd6
  } reg_idx_t;

  // Listed from the top bit down, so that origin x lands in the lowest bits of tdata.
  typedef struct packed {
    logic signed [DATA_W-1:0] tmax;
    logic signed [DATA_W-1:0] tmin;
    logic signed [DATA_W-1:0] dz;
    logic signed [DATA_W-1:0] dy;
    logic signed [DATA_W-1:0] dx;
    logic signed [DATA_W-1:0] oz;
    logic signed [DATA_W-1:0] oy;
    logic signed [DATA_W-1:0] ox;
  } ray_t;

  // Control that travels beside the t quotient.
  typedef struct packed {
    ray_t ray;
    logic nneg;
    logic live;
    logic qneg;
  } tcarry_t;

  // Control and finished fields that travel beside the u and v quotients.
  typedef struct packed {
    logic                     live;
    logic                     nneg;
    logic        [DATA_W-1:0] t;
    logic        [DATA_W-1:0] px;
    logic        [DATA_W-1:0] py;
    logic        [DATA_W-1:0] pz;
    logic                     zero_u;
    logic                     zero_v;
  } uvcarry_t;

  // One restoring division step: returns {new remainder, quotient bit}.
  // The remainder on entry must be below the divisor.
  function automatic logic [DATA_W:0] div_step(logic [DATA_W-1:0] rem, logic bin,
                                               logic [DATA_W-1:0] dvs);
    logic [DATA_W:0] trial;
    logic [DATA_W:0] diff;
    trial = {rem, bin};
    diff  = trial - {1'b0, dvs};
    if (trial >= {1'b0, dvs}) begin
      return {diff[DATA_W-1:0], 1'b1};
    end
    return {trial[DATA_W-1:0], 1'b0};
  endfunction

  function automatic logic [DATA_W-1:0] sat_pt(logic signed [PT_W-1:0] v);
    if ((&v[PT_W-1:DATA_W-1]) || !(|v[PT_W-1:DATA_W-1])) begin
      return v[DATA_W-1:0];
    end
    return v[PT_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
  endfunction

endpackage

@@ rtl/core/ray_axis_rect_intersect.sv @@
// Top level of the ray against axis-aligned rectangle intersection block.
// Depends on rai_pkg, rai_tdiv and rai_uvdiv.
//
// Each ray item yields exactly one result item, and a new ray can be taken in every
// cycle in which no result waits at the output. The pipeline holds the two dividers:
// 32 stages for the ray parameter t and 17 stages for u and v, plus six stages for setup,
// the interval test, the three multipliers, the hit point adders, the bounds test and the
// output register. The whole pipeline advances together; while a result waits at the
// output, every stage holds. A miss gives hit = 0 and every other field 0. The
// rectangle registers are to be written only while no item is in flight.
module ray_axis_rect_intersect (
  input  logic         clk,
  input  logic         rst,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_min, t_max (32 bits each)
  input  logic [255:0] s_axis_tdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // hit_t[31:0], tex_u[48:32], tex_v[65:49], point_x[97:66], point_y[129:98],
  // point_z[161:130], normal_negative[162], hit_material[170:163], zero fill
  output logic [175:0] m_axis_tdata,
  // hit
  output logic [0:0]   m_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int W    = rai_pkg::DATA_W;
  localparam int PT_W = rai_pkg::PT_W;
  localparam int UVW  = rai_pkg::UV_STEPS;

  logic [1:0]          plane_axis;
  logic signed [W-1:0] plane_position;
  logic signed [W-1:0] first_axis_low;
  logic signed [W-1:0] first_axis_high;
  logic signed [W-1:0] second_axis_low;
  logic signed [W-1:0] second_axis_high;
  logic [7:0]          material_id;

  logic en;

  assign cfg_ready     = 1'b1;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_axis       <= rai_pkg::AXIS_Z;
      plane_position   <= '0;
      first_axis_low   <= '0;
      first_axis_high  <= '0;
      second_axis_low  <= '0;
      second_axis_high <= '0;
      material_id      <= '0;
    end else if (cfg_valid) begin
      case (rai_pkg::reg_idx_t'(cfg_index))
        rai_pkg::REG_PLANE_AXIS:  plane_axis       <= cfg_data[1:0];
        rai_pkg::REG_PLANE_POS:   plane_position   <= cfg_data;
        rai_pkg::REG_FIRST_LOW:   first_axis_low   <= cfg_data;
        rai_pkg::REG_FIRST_HIGH:  first_axis_high  <= cfg_data;
        rai_pkg::REG_SECOND_LOW:  second_axis_low  <= cfg_data;
        rai_pkg::REG_SECOND_HIGH: second_axis_high <= cfg_data;
        rai_pkg::REG_MATERIAL:    material_id      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Setup stage: pick the normal axis and form the divider operands.
  rai_pkg::ray_t       ray_in;
  logic signed [W-1:0] o_n;
  logic signed [W-1:0] d_n;
  logic                axis_ok;
  logic signed [W:0]   num;
  logic [W:0]          num_mag;
  logic [W-1:0]        dmag;
  rai_pkg::tcarry_t    c0_next;

  assign ray_in = rai_pkg::ray_t'(s_axis_tdata);

  always_comb begin
    axis_ok = 1'b1;
    case (plane_axis)
      rai_pkg::AXIS_Z: begin
        o_n = ray_in.oz;
        d_n = ray_in.dz;
      end
      rai_pkg::AXIS_Y: begin
        o_n = ray_in.oy;
        d_n = ray_in.dy;
      end
      rai_pkg::AXIS_X: begin
        o_n = ray_in.ox;
        d_n = ray_in.dx;
      end
      default: begin
        o_n     = '0;
        d_n     = '0;
        axis_ok = 1'b0;
      end
    endcase
    num     = (W+1)'(plane_position) - (W+1)'(o_n);
    num_mag = num[W] ? (W+1)'(-num) : num;
    dmag    = d_n[W-1] ? W'(-d_n) : d_n;
    c0_next.ray  = ray_in;
    c0_next.nneg = !d_n[W-1] && (d_n != '0);
    c0_next.live = axis_ok && (d_n != '0);
    c0_next.qneg = num[W] ^ d_n[W-1];
  end

  logic              v0;
  rai_pkg::tcarry_t  c0;
  logic [W:0]        num_mag0;
  logic [W-1:0]      dmag0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c0       <= c0_next;
      num_mag0 <= num_mag;
      dmag0    <= dmag;
    end
  end

  logic              vq;
  rai_pkg::tcarry_t  cq;
  logic [W-1:0]      qmag;

  rai_tdiv u_tdiv (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (v0),
    .in_carry   (c0),
    .in_num_mag (num_mag0),
    .in_dmag    (dmag0),
    .out_valid  (vq),
    .out_carry  (cq),
    .out_qmag   (qmag)
  );

  // Interval test on the signed quotient.
  logic signed [W:0] tq;
  logic              in_interval;

  always_comb begin
    tq = cq.qneg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    in_interval = (tq >= (W+1)'(cq.ray.tmin)) && (tq <= (W+1)'(cq.ray.tmax));
  end

  logic                v1;
  rai_pkg::ray_t       ray1;
  logic                nneg1;
  logic                live1;
  logic signed [W-1:0] t1;

  // Multiply stage.
  logic                  v2;
  rai_pkg::ray_t         ray2;
  logic                  nneg2;
  logic                  live2;
  logic signed [W-1:0]   t2;
  logic signed [2*W-1:0] prod_x;
  logic signed [2*W-1:0] prod_y;
  logic signed [2*W-1:0] prod_z;

  // Hit point stage.
  logic                 v3;
  logic                 nneg3;
  logic                 live3;
  logic signed [W-1:0]  t3;
  logic signed [PT_W-1:0] pt_x;
  logic signed [PT_W-1:0] pt_y;
  logic signed [PT_W-1:0] pt_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= vq;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ray1   <= cq.ray;
      nneg1  <= cq.nneg;
      live1  <= cq.live && in_interval;
      t1     <= tq[W-1:0];

      ray2   <= ray1;
      nneg2  <= nneg1;
      live2  <= live1;
      t2     <= t1;
      prod_x <= t1 * ray1.dx;
      prod_y <= t1 * ray1.dy;
      prod_z <= t1 * ray1.dz;

      nneg3  <= nneg2;
      live3  <= live2;
      t3     <= t2;
      pt_x   <= PT_W'(ray2.ox) + PT_W'(prod_x >>> rai_pkg::FRAC_BITS);
      pt_y   <= PT_W'(ray2.oy) + PT_W'(prod_y >>> rai_pkg::FRAC_BITS);
      pt_z   <= PT_W'(ray2.oz) + PT_W'(prod_z >>> rai_pkg::FRAC_BITS);
    end
  end

  // Bounds test and u, v operands.
  logic signed [PT_W-1:0] pa1;
  logic signed [PT_W-1:0] pa2;
  logic signed [PT_W-1:0] lo1;
  logic signed [PT_W-1:0] hi1;
  logic signed [PT_W-1:0] lo2;
  logic signed [PT_W-1:0] hi2;
  logic signed [PT_W-1:0] diff1;
  logic signed [PT_W-1:0] diff2;
  logic signed [PT_W-1:0] span1;
  logic signed [PT_W-1:0] span2;
  logic                   in_bounds;
  rai_pkg::uvcarry_t      c4_next;

  always_comb begin
    case (plane_axis)
      rai_pkg::AXIS_Z: begin
        pa1 = pt_x;
        pa2 = pt_y;
      end
      rai_pkg::AXIS_Y: begin
        pa1 = pt_x;
        pa2 = pt_z;
      end
      default: begin
        pa1 = pt_y;
        pa2 = pt_z;
      end
    endcase
    lo1   = PT_W'(first_axis_low);
    hi1   = PT_W'(first_axis_high);
    lo2   = PT_W'(second_axis_low);
    hi2   = PT_W'(second_axis_high);
    diff1 = pa1 - lo1;
    diff2 = pa2 - lo2;
    span1 = hi1 - lo1;
    span2 = hi2 - lo2;
    in_bounds = (pa1 >= lo1) && (pa1 <= hi1) && (pa2 >= lo2) && (pa2 <= hi2);
    c4_next.live   = live3 && in_bounds;
    c4_next.nneg   = nneg3;
    c4_next.t      = t3;
    c4_next.px     = rai_pkg::sat_pt(pt_x);
    c4_next.py     = rai_pkg::sat_pt(pt_y);
    c4_next.pz     = rai_pkg::sat_pt(pt_z);
    c4_next.zero_u = (first_axis_high == first_axis_low);
    c4_next.zero_v = (second_axis_high == second_axis_low);
  end

  logic               v4;
  rai_pkg::uvcarry_t  c4;
  logic [W-1:0]       diff_u4;
  logic [W-1:0]       diff_v4;
  logic [W-1:0]       span_u4;
  logic [W-1:0]       span_v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  // On a live item both differences lie between 0 and the span, below 2^32.
  always_ff @(posedge clk) begin
    if (en) begin
      c4      <= c4_next;
      diff_u4 <= diff1[W-1:0];
      diff_v4 <= diff2[W-1:0];
      span_u4 <= span1[W-1:0];
      span_v4 <= span2[W-1:0];
    end
  end

  logic               vu;
  rai_pkg::uvcarry_t  cu;
  logic [UVW-1:0]     q_u;
  logic [UVW-1:0]     q_v;

  rai_uvdiv u_uvdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .in_carry  (c4),
    .in_diff_u (diff_u4),
    .in_span_u (span_u4),
    .in_diff_v (diff_v4),
    .in_span_v (span_v4),
    .out_valid (vu),
    .out_carry (cu),
    .out_u     (q_u),
    .out_v     (q_v)
  );

  logic [175:0] tdata_next;
  logic [UVW-1:0] tex_u;
  logic [UVW-1:0] tex_v;

  always_comb begin
    tex_u = cu.zero_u ? '0 : q_u;
    tex_v = cu.zero_v ? '0 : q_v;
    tdata_next = '0;
    if (cu.live) begin
      tdata_next[31:0]    = cu.t;
      tdata_next[48:32]   = tex_u;
      tdata_next[65:49]   = tex_v;
      tdata_next[97:66]   = cu.px;
      tdata_next[129:98]  = cu.py;
      tdata_next[161:130] = cu.pz;
      tdata_next[162]     = cu.nneg;
      tdata_next[170:163] = material_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= vu;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata    <= tdata_next;
      m_axis_tuser[0] <= cu.live;
    end
  end

endmodule

@@ rtl/core/rai_tdiv.sv @@
// Pipelined restoring divider for the ray parameter: one quotient bit per stage.
// Depends on rai_pkg.
module rai_tdiv (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  rai_pkg::tcarry_t              in_carry,
  input  logic [rai_pkg::DATA_W:0]      in_num_mag,
  input  logic [rai_pkg::DATA_W-1:0]    in_dmag,
  output logic                          out_valid,
  output rai_pkg::tcarry_t              out_carry,
  output logic [rai_pkg::DATA_W-1:0]    out_qmag
);

  localparam int STEPS = rai_pkg::TDIV_STEPS;
  localparam int W     = rai_pkg::DATA_W;
  localparam int HI_SH = W - rai_pkg::FRAC_BITS;

  logic [STEPS-1:0]  vld;
  logic [W-1:0]      rem  [STEPS];
  logic [W-1:0]      qd   [STEPS];
  logic [W-1:0]      dvs  [STEPS];
  rai_pkg::tcarry_t  cr   [STEPS];
  logic [W:0]        stp  [STEPS];

  logic [W-1:0]      rem_in;
  logic [W-1:0]      qd_in;
  logic              ovf;
  rai_pkg::tcarry_t  carry_in;

  // The scaled numerator is split: its top part starts the remainder and its
  // low part is shifted in one bit per stage, quotient bits filling in behind.
  always_comb begin
    rem_in = W'(in_num_mag >> HI_SH);
    qd_in  = {in_num_mag[HI_SH-1:0], {rai_pkg::FRAC_BITS{1'b0}}};
    // A quotient of 2^32 or more can never fall inside a 32-bit interval.
    ovf    = (in_num_mag >> HI_SH) >= {1'b0, in_dmag};
    carry_in      = in_carry;
    carry_in.live = in_carry.live && !ovf;
    stp[0] = rai_pkg::div_step(rem_in, qd_in[W-1], in_dmag);
    for (int k = 1; k < STEPS; k++) begin
      stp[k] = rai_pkg::div_step(rem[k-1], qd[k-1][W-1], dvs[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= stp[0][W:1];
      qd[0]  <= {qd_in[W-2:0], stp[0][0]};
      dvs[0] <= in_dmag;
      cr[0]  <= carry_in;
      for (int k = 1; k < STEPS; k++) begin
        rem[k] <= stp[k][W:1];
        qd[k]  <= {qd[k-1][W-2:0], stp[k][0]};
        dvs[k] <= dvs[k-1];
        cr[k]  <= cr[k-1];
      end
    end
  end

  assign out_valid = vld[STEPS-1];
  assign out_carry = cr[STEPS-1];
  assign out_qmag  = qd[STEPS-1];

endmodule

@@ rtl/core/rai_uvdiv.sv @@
// Two-lane pipelined restoring divider for the u and v texture coordinates.
// Depends on rai_pkg.
module rai_uvdiv (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  rai_pkg::uvcarry_t                   in_carry,
  input  logic [rai_pkg::DATA_W-1:0]          in_diff_u,
  input  logic [rai_pkg::DATA_W-1:0]          in_span_u,
  input  logic [rai_pkg::DATA_W-1:0]          in_diff_v,
  input  logic [rai_pkg::DATA_W-1:0]          in_span_v,
  output logic                                out_valid,
  output rai_pkg::uvcarry_t                   out_carry,
  output logic [rai_pkg::UV_STEPS-1:0]        out_u,
  output logic [rai_pkg::UV_STEPS-1:0]        out_v
);

  localparam int STEPS = rai_pkg::UV_STEPS;
  localparam int W     = rai_pkg::DATA_W;

  logic [STEPS-1:0]   vld;
  rai_pkg::uvcarry_t  cr [STEPS];
  logic [W-1:0]       diff_in [2];
  logic [W-1:0]       span_in [2];
  logic [STEPS-1:0]   lane_q  [2];

  assign diff_in[0] = in_diff_u;
  assign diff_in[1] = in_diff_v;
  assign span_in[0] = in_span_u;
  assign span_in[1] = in_span_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cr[0] <= in_carry;
      for (int k = 1; k < STEPS; k++) begin
        cr[k] <= cr[k-1];
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [W-1:0]     rem [STEPS];
    logic [STEPS-1:0] qd  [STEPS];
    logic [W-1:0]     dvs [STEPS];
    logic [W:0]       stp [STEPS];
    logic [W-1:0]     rem_in;
    logic [STEPS-1:0] qd_in;

    // Dividend is diff * 2^16; its bits above the quotient field start the
    // remainder, which stays below the span since diff never exceeds it.
    always_comb begin
      rem_in = diff_in[l] >> 1;
      qd_in  = {diff_in[l][0], {rai_pkg::UV_BITS{1'b0}}};
      stp[0] = rai_pkg::div_step(rem_in, qd_in[STEPS-1], span_in[l]);
      for (int k = 1; k < STEPS; k++) begin
        stp[k] = rai_pkg::div_step(rem[k-1], qd[k-1][STEPS-1], dvs[k-1]);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[0] <= stp[0][W:1];
        qd[0]  <= {qd_in[STEPS-2:0], stp[0][0]};
        dvs[0] <= span_in[l];
        for (int k = 1; k < STEPS; k++) begin
          rem[k] <= stp[k][W:1];
          qd[k]  <= {qd[k-1][STEPS-2:0], stp[k][0]};
          dvs[k] <= dvs[k-1];
        end
      end
    end

    assign lane_q[l] = qd[STEPS-1];
  end

  assign out_valid = vld[STEPS-1];
  assign out_carry = cr[STEPS-1];
  assign out_u     = lane_q[0];
  assign out_v     = lane_q[1];

endmodule
